>>> design/line_pixel_generator_macros.svh
// line_pixel_generator_macros.svh: assertion macros for the line pixel generator.
// Included by the RTL file that carries assertions; needs no other file.
`ifndef LINE_PIXEL_GENERATOR_MACROS_SVH
`define LINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define LPG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lpg_pkg.sv
// lpg_pkg: widths, constants, state and interface types of the line pixel generator.
// Used by lpg_div, lpg_blend and line_pixel_generator; depends on nothing.
`default_nettype none

package lpg_pkg;

  localparam int COORD_WIDTH_DEF = 12;

  localparam int RAW_W    = 9;
  localparam int SCALE_W  = 4;
  localparam int PIX_W    = 12;
  localparam int DELTA_W  = PIX_W + 1;
  localparam int PROD_W   = 2 * DELTA_W;
  localparam int QUOT_W   = PIX_W;
  localparam int DEN_W    = PIX_W;
  localparam int NUM_W    = QUOT_W + DEN_W;
  localparam int CNT_W    = $clog2(QUOT_W + 1);

  localparam int TRANS_W    = 7;
  localparam int COL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [SCALE_W-1:0] SCALE_MIN   = 4'd1;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 4'd8;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

  localparam logic [TRANS_W-1:0] TRANS_MAX = 7'd100;
  localparam logic [COL_W-1:0]   WHITE     = 8'd255;

  // floor(v / 100) == (v * 5243) >> 19 for every v up to 25500
  localparam int BLEND_W     = 15;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] BLEND_RECIP = 13'd5243;
  localparam int BLEND_SHIFT = 19;

  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] BLEND_LAT = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 3'd0,
    CFG_TRANS = 3'd1,
    CFG_RED   = 3'd2,
    CFG_GREEN = 3'd3,
    CFG_BLUE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_START,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_EMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [QUOT_W-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> design/lpg_div.sv
// lpg_div: unsigned restoring divider, one quotient bit per cycle.
// Needs lpg_pkg; numerator must be below den * 2**QUOT_W.
`default_nettype none

module lpg_div (
  input  logic              clk,
  input  logic              rst,
  input  lpg_pkg::div_req_t req,
  output lpg_pkg::div_rsp_t rsp
);

  logic [lpg_pkg::DEN_W-1:0]  rem;
  logic [lpg_pkg::QUOT_W-1:0] quot;
  logic [lpg_pkg::DEN_W-1:0]  den;
  logic [lpg_pkg::CNT_W-1:0]  cnt;
  logic                       busy;

  logic [lpg_pkg::DEN_W+1:0]  diff;
  logic                       fits;
  logic [lpg_pkg::DEN_W-1:0]  rem_next;

  always_comb begin
    diff     = {1'b0, rem, quot[lpg_pkg::QUOT_W-1]} - {2'b00, den};
    fits     = !diff[lpg_pkg::DEN_W+1];
    rem_next = fits ? diff[lpg_pkg::DEN_W-1:0]
                    : {rem[lpg_pkg::DEN_W-2:0], quot[lpg_pkg::QUOT_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= lpg_pkg::CNT_W'(lpg_pkg::QUOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == lpg_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // quot starts as the low numerator bits and fills with quotient bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num[lpg_pkg::NUM_W-1 -: lpg_pkg::DEN_W];
      quot <= req.num[lpg_pkg::QUOT_W-1:0];
      den  <= req.den;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[lpg_pkg::QUOT_W-2:0], fits};
    end
  end

  assign rsp.busy   = busy;
  assign rsp.quot   = quot;
  assign rsp.rem_nz = (rem != '0);

endmodule

`default_nettype wire

>>> design/lpg_blend.sv
// lpg_blend: two-stage pipeline blending the line colour toward white.
// Needs lpg_pkg; the mix sums are registered, then divided by 100 into the registered result.
`default_nettype none

module lpg_blend (
  input  logic                          clk,
  input  logic [lpg_pkg::TRANS_W-1:0]   transparency,
  input  lpg_pkg::rgb_t                 colour,
  output lpg_pkg::rgb_t                 blended
);

  logic [lpg_pkg::TRANS_W-1:0] tc;
  logic [lpg_pkg::TRANS_W-1:0] inv;
  logic [lpg_pkg::BLEND_W-1:0] v_red;
  logic [lpg_pkg::BLEND_W-1:0] v_green;
  logic [lpg_pkg::BLEND_W-1:0] v_blue;

  function automatic logic [lpg_pkg::BLEND_W-1:0] mix(
    input logic [lpg_pkg::TRANS_W-1:0] t,
    input logic [lpg_pkg::TRANS_W-1:0] ti,
    input logic [lpg_pkg::COL_W-1:0]   c
  );
    logic [lpg_pkg::BLEND_W-1:0] a;
    logic [lpg_pkg::BLEND_W-1:0] b;
    a   = lpg_pkg::BLEND_W'(ti * c);
    b   = lpg_pkg::BLEND_W'(t * lpg_pkg::WHITE);
    mix = a + b;
  endfunction

  function automatic logic [lpg_pkg::COL_W-1:0] div100(
    input logic [lpg_pkg::BLEND_W-1:0] v
  );
    logic [lpg_pkg::BLEND_W+lpg_pkg::RECIP_W-1:0] p;
    p      = v * lpg_pkg::BLEND_RECIP;
    div100 = p[lpg_pkg::BLEND_SHIFT +: lpg_pkg::COL_W];
  endfunction

  always_comb begin
    tc  = (transparency > lpg_pkg::TRANS_MAX) ? lpg_pkg::TRANS_MAX : transparency;
    inv = lpg_pkg::TRANS_MAX - tc;
  end

  always_ff @(posedge clk) begin
    v_red   <= mix(tc, inv, colour.red);
    v_green <= mix(tc, inv, colour.green);
    v_blue  <= mix(tc, inv, colour.blue);
  end

  always_ff @(posedge clk) begin
    blended.red   <= div100(v_red);
    blended.green <= div100(v_green);
    blended.blue  <= div100(v_blue);
  end

endmodule

`default_nettype wire

>>> design/line_pixel_generator.sv
// line_pixel_generator: line rasteriser, at most one pixel per request, exact floor slope.
// Needs lpg_pkg, lpg_div, lpg_blend and line_pixel_generator_macros.svh.
//
// Use: a request with command 0 loads two endpoints (scaled by the scale
// register) and returns the first pixel; each request with command 1 returns
// the next pixel. Every request gives exactly one result; valid_res marks a
// result that carries a pixel, last marks the final pixel or an empty line.
// Input and output channels use valid/stall; configuration writes use
// cfg_valid/cfg_ready with a register index and are taken every cycle.
// One request is worked on at a time. A sloped tick passes through ST_MUL,
// ST_DLOAD, ST_DIV, ST_EMIT and ST_OUT before out_valid rises; a start
// request passes ST_SCALE and ST_START first. In ST_DIV the divider produces
// one quotient bit per cycle. Vertical pixels and results without a pixel
// skip the divider. The next request is taken in ST_IDLE, which follows the
// loading of a result. in_stall is high while a request is worked on and,
// after a configuration write, while the settle counter runs down and the
// colour pipeline settles. A finished result waits in the output register
// while out_stall is high and the next request is already accepted; its own
// result then waits until the register is taken. Reset loads the register
// defaults, drops any line in progress and empties the output register.
`default_nettype none
`include "line_pixel_generator_macros.svh"

module line_pixel_generator #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpg_pkg::CFG_DATA_W-1:0]    cfg_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [lpg_pkg::RAW_W-1:0]         x_start,
  input  logic [lpg_pkg::RAW_W-1:0]         y_start,
  input  logic [lpg_pkg::RAW_W-1:0]         x_end,
  input  logic [lpg_pkg::RAW_W-1:0]         y_end,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lpg_pkg::PIX_W-1:0]         pixel_x,
  output logic [lpg_pkg::PIX_W-1:0]         pixel_y,
  output logic [lpg_pkg::COL_W-1:0]         red_out,
  output logic [lpg_pkg::COL_W-1:0]         green_out,
  output logic [lpg_pkg::COL_W-1:0]         blue_out,
  output logic                              valid_res,
  output logic                              last
);

  localparam logic [lpg_pkg::PIX_W-1:0] PIX_MASK =
    (COORD_WIDTH >= lpg_pkg::PIX_W) ? {lpg_pkg::PIX_W{1'b1}}
                                    : lpg_pkg::PIX_W'((1 << COORD_WIDTH) - 1);

  // configuration
  logic [lpg_pkg::SCALE_W-1:0]  scale;
  logic [lpg_pkg::TRANS_W-1:0]  transparency;
  lpg_pkg::rgb_t                colour;
  lpg_pkg::rgb_t                blended;
  logic [lpg_pkg::SETTLE_W-1:0] settle;
  logic [lpg_pkg::SCALE_W-1:0]  s_eff;

  // sequencer
  lpg_pkg::state_t state;
  lpg_pkg::state_t state_next;
  logic            accept;
  logic            out_free;
  logic            out_load;

  // request
  logic                      cmd;
  logic [lpg_pkg::RAW_W-1:0] xs;
  logic [lpg_pkg::RAW_W-1:0] ys;
  logic [lpg_pkg::RAW_W-1:0] xe;
  logic [lpg_pkg::RAW_W-1:0] ye;
  logic [lpg_pkg::PIX_W-1:0] sx1;
  logic [lpg_pkg::PIX_W-1:0] sy1;
  logic [lpg_pkg::PIX_W-1:0] sx2;
  logic [lpg_pkg::PIX_W-1:0] sy2;

  // line state
  logic [lpg_pkg::PIX_W-1:0]          walk_pos;
  logic [lpg_pkg::PIX_W-1:0]          remaining;
  logic [lpg_pkg::PIX_W-1:0]          base_x;
  logic [lpg_pkg::PIX_W-1:0]          base_y;
  logic signed [lpg_pkg::DELTA_W-1:0] delta_x;
  logic signed [lpg_pkg::DELTA_W-1:0] delta_y;
  logic                               vertical_mode;
  logic                               active;

  // start set-up
  logic signed [lpg_pkg::DELTA_W-1:0] dx_s;
  logic signed [lpg_pkg::DELTA_W-1:0] dy_s;
  logic [lpg_pkg::DELTA_W-1:0]        abs_dx;
  logic [lpg_pkg::DELTA_W-1:0]        abs_dy;
  logic                               start_vert;
  logic [lpg_pkg::PIX_W-1:0]          start_rem;
  logic [lpg_pkg::PIX_W-1:0]          start_walk;

  // slope
  logic signed [lpg_pkg::DELTA_W-1:0] walk_off;
  logic signed [lpg_pkg::PROD_W-1:0]  prod;
  logic [lpg_pkg::PROD_W-1:0]         prod_abs;
  logic [lpg_pkg::DELTA_W-1:0]        dx_abs;
  logic                               neg;
  logic [lpg_pkg::DELTA_W-1:0]        mag;
  logic [lpg_pkg::DELTA_W:0]          off;
  logic [lpg_pkg::DELTA_W:0]          y_sum;
  lpg_pkg::div_req_t                  div_req;
  lpg_pkg::div_rsp_t                  div_rsp;

  // result
  logic [lpg_pkg::PIX_W-1:0] res_x;
  logic [lpg_pkg::PIX_W-1:0] res_y;
  logic                      res_valid;
  logic                      res_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= lpg_pkg::SCALE_RESET;
      transparency <= '0;
      colour       <= '0;
      settle       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      settle <= lpg_pkg::BLEND_LAT;
      unique case (cfg_index)
        lpg_pkg::CFG_SCALE: scale        <= cfg_data[lpg_pkg::SCALE_W-1:0];
        lpg_pkg::CFG_TRANS: transparency <= cfg_data[lpg_pkg::TRANS_W-1:0];
        lpg_pkg::CFG_RED:   colour.red   <= cfg_data;
        lpg_pkg::CFG_GREEN: colour.green <= cfg_data;
        lpg_pkg::CFG_BLUE:  colour.blue  <= cfg_data;
        default: ;
      endcase
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  lpg_blend u_blend (
    .clk          (clk),
    .transparency (transparency),
    .colour       (colour),
    .blended      (blended)
  );

  lpg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (scale < lpg_pkg::SCALE_MIN) begin
      s_eff = lpg_pkg::SCALE_MIN;
    end else if (scale > lpg_pkg::SCALE_MAX) begin
      s_eff = lpg_pkg::SCALE_MAX;
    end else begin
      s_eff = scale;
    end
  end

  always_comb begin
    dx_s       = $signed({1'b0, sx2}) - $signed({1'b0, sx1});
    dy_s       = $signed({1'b0, sy2}) - $signed({1'b0, sy1});
    abs_dx     = dx_s[lpg_pkg::DELTA_W-1] ? -dx_s : dx_s;
    abs_dy     = dy_s[lpg_pkg::DELTA_W-1] ? -dy_s : dy_s;
    start_vert = (dx_s == '0);
    start_rem  = start_vert ? abs_dy[lpg_pkg::PIX_W-1:0] : abs_dx[lpg_pkg::PIX_W-1:0];
    if (start_vert) begin
      start_walk = (sy1 < sy2) ? sy1 : sy2;
    end else begin
      start_walk = (sx1 < sx2) ? sx1 : sx2;
    end
  end

  always_comb begin
    walk_off = $signed({1'b0, walk_pos}) - $signed({1'b0, base_x});
    prod_abs = prod[lpg_pkg::PROD_W-1] ? -prod : prod;
    dx_abs   = delta_x[lpg_pkg::DELTA_W-1] ? -delta_x : delta_x;
    mag      = {1'b0, div_rsp.quot} + lpg_pkg::DELTA_W'(neg && div_rsp.rem_nz);
    off      = neg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
    y_sum    = {2'b00, base_y} + off;
  end

  always_comb begin
    div_req.num = prod_abs[lpg_pkg::NUM_W-1:0];
    div_req.den = dx_abs[lpg_pkg::DEN_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpg_pkg::ST_IDLE:  begin
        if (accept) begin
          state_next = (command == lpg_pkg::CMD_TICK) ? lpg_pkg::ST_MUL : lpg_pkg::ST_SCALE;
        end
      end
      lpg_pkg::ST_SCALE: state_next = lpg_pkg::ST_START;
      lpg_pkg::ST_START: begin
        state_next = (start_rem == '0) ? lpg_pkg::ST_OUT : lpg_pkg::ST_MUL;
      end
      lpg_pkg::ST_MUL:   begin
        if (!active || remaining == '0) begin
          state_next = lpg_pkg::ST_OUT;
        end else if (vertical_mode) begin
          state_next = lpg_pkg::ST_EMIT;
        end else begin
          state_next = lpg_pkg::ST_DLOAD;
        end
      end
      lpg_pkg::ST_DLOAD: state_next = lpg_pkg::ST_DIV;
      lpg_pkg::ST_DIV:   begin
        if (!div_rsp.busy) begin
          state_next = lpg_pkg::ST_EMIT;
        end
      end
      lpg_pkg::ST_EMIT:  state_next = lpg_pkg::ST_OUT;
      lpg_pkg::ST_OUT:   begin
        if (out_free) begin
          state_next = lpg_pkg::ST_IDLE;
        end
      end
      default:           state_next = lpg_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = (state != lpg_pkg::ST_IDLE) || (settle != '0);
    accept        = in_valid && !in_stall;
    out_free      = !out_valid || !out_stall;
    out_load      = (state == lpg_pkg::ST_OUT) && out_free;
    div_req.start = (state == lpg_pkg::ST_DLOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpg_pkg::ST_IDLE;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        lpg_pkg::ST_START: active <= (start_rem != '0);
        lpg_pkg::ST_MUL:   begin
          if (remaining == '0) begin
            active <= 1'b0;
          end
        end
        lpg_pkg::ST_EMIT:  active <= (remaining != lpg_pkg::PIX_W'(1));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lpg_pkg::ST_IDLE: begin
        if (accept) begin
          cmd <= command;
          xs  <= x_start;
          ys  <= y_start;
          xe  <= x_end;
          ye  <= y_end;
        end
      end
      lpg_pkg::ST_SCALE: begin
        sx1 <= lpg_pkg::PIX_W'(xs * s_eff);
        sy1 <= lpg_pkg::PIX_W'(ys * s_eff);
        sx2 <= lpg_pkg::PIX_W'(xe * s_eff);
        sy2 <= lpg_pkg::PIX_W'(ye * s_eff);
      end
      lpg_pkg::ST_START: begin
        base_x        <= sx1;
        base_y        <= sy1;
        delta_x       <= dx_s;
        delta_y       <= dy_s;
        vertical_mode <= start_vert;
        walk_pos      <= start_walk;
        remaining     <= start_rem;
        res_x         <= '0;
        res_y         <= '0;
        res_valid     <= 1'b0;
        res_last      <= 1'b1;
      end
      lpg_pkg::ST_MUL: begin
        prod      <= lpg_pkg::PROD_W'(delta_y) * lpg_pkg::PROD_W'(walk_off);
        res_x     <= '0;
        res_y     <= '0;
        res_valid <= 1'b0;
        res_last  <= 1'b0;
      end
      lpg_pkg::ST_DLOAD: neg <= prod[lpg_pkg::PROD_W-1] ^ delta_x[lpg_pkg::DELTA_W-1];
      lpg_pkg::ST_EMIT: begin
        res_x     <= vertical_mode ? base_x : walk_pos;
        res_y     <= vertical_mode ? walk_pos : y_sum[lpg_pkg::PIX_W-1:0];
        res_valid <= 1'b1;
        res_last  <= (remaining == lpg_pkg::PIX_W'(1));
        remaining <= remaining - 1'b1;
        walk_pos  <= walk_pos + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_x   <= res_x & PIX_MASK;
      pixel_y   <= res_y & PIX_MASK;
      red_out   <= res_valid ? blended.red   : '0;
      green_out <= res_valid ? blended.green : '0;
      blue_out  <= res_valid ? blended.blue  : '0;
      valid_res <= res_valid;
      last      <= res_last && (cmd == lpg_pkg::CMD_START || res_valid);
    end
  end

  `LPG_ASSERT_IMP(a_active_has_work, clk, rst,
    state == lpg_pkg::ST_IDLE && active, remaining != '0,
    "line active with nothing left")
  `LPG_ASSERT_NXT(a_out_held, clk, rst,
    state == lpg_pkg::ST_OUT && out_valid && out_stall, state == lpg_pkg::ST_OUT,
    "result left while output register full")
  `LPG_ASSERT_IMP(a_div_in_div, clk, rst,
    div_rsp.busy, state == lpg_pkg::ST_DIV,
    "divider running outside divide state")
  `LPG_ASSERT_IMP(a_no_vert_div, clk, rst,
    state == lpg_pkg::ST_DLOAD, !vertical_mode && delta_x != '0,
    "divide started on a vertical line")
  `LPG_ASSERT_IMP(a_empty_zero, clk, rst,
    out_valid && !valid_res,
    pixel_x == '0 && pixel_y == '0 && red_out == '0 && green_out == '0 && blue_out == '0,
    "empty result carries data")

endmodule

`default_nettype wire
